// ===== hw/rtl/tcw_pkg.sv =====
// Package for the text console writer: channel payload types, request codes,
// command types passed from the front end to the back end. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int ROWS_DEFAULT = 25;
   localparam int COLS_DEFAULT = 80;

   localparam logic [7:0] ATTR_RESET   = 8'h0F;
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;

   // request codes on the input channel
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_SET   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
      logic [10:0] cursor_now;
      logic        scrolled;
   } rsp_item_type;

   typedef enum logic [2:0] {
      OP_PUTC,
      OP_NEWLINE,
      OP_SETCUR,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
      logic        in_range;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
      logic pop;
   } back_stat_type;

endpackage

// ===== hw/rtl/tcw_front.sv =====
// Front end of the text console writer: accepts request words, decodes them
// into commands and holds them in a two-entry queue. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_front #(
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
   parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcw_pkg::req_item_type req_item,
   input  tcw_pkg::back_stat_type back_stat,
   output logic                  cmd_valid,
   output tcw_pkg::cmd_type      cmd
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = ROWS * COLS;

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    decoded;
   logic       push;

   always_comb begin
      decoded.char_code  = req_item.char_code;
      decoded.cell_index = req_item.cell_index;
      decoded.in_range   = (32'(req_item.cell_index) < 32'(CELL_COUNT));
      case (req_item.req_type)
         REQ_PUT: begin
            decoded.op = (req_item.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUTC;
         end
         REQ_SET:   decoded.op = OP_SETCUR;
         REQ_CLEAR: decoded.op = OP_CLEAR;
         REQ_READ:  decoded.op = OP_READ;
         default:   decoded.op = OP_READ;
      endcase
   end

   // hold off requests while the queue is full or the store is being cleared after reset
   assign req_stall = (count_ff == 2'd2) || back_stat.init_busy;
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = back_stat.pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !back_stat.pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && back_stat.pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// Back end of the text console writer: cell store, cursor, sequencer for
// write, scroll, clear, cursor set and read, and the result register.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_back #(
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
   parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  tcw_pkg::cmd_type       cmd,
   input  logic [7:0]             text_attr,
   output tcw_pkg::back_stat_type back_stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tcw_pkg::rsp_item_type  rsp_item
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = ROWS * COLS;
   localparam int CELL_W     = $clog2(CELL_COUNT + 1);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLS);
   // reciprocal of COLS, exact for every index below 2**CELL_W
   localparam int Q_SHIFT    = CELL_W + COL_W;
   localparam int RECIP      = ((1 << Q_SHIFT) + COLS - 1) / COLS;
   localparam int RECIP_W    = $clog2(RECIP + 1);
   localparam int PROD_W     = CELL_W + RECIP_W;

   localparam logic [CELL_W-1:0]  CELLS    = CELL_W'(CELL_COUNT);
   localparam logic [CELL_W-1:0]  LAST_ONE = CELL_W'(CELL_COUNT - 1);
   localparam logic [CELL_W-1:0]  LAST_ROW = CELL_W'(CELL_COUNT - COLS);
   localparam logic [CELL_W-1:0]  COLS_C   = CELL_W'(COLS);
   localparam logic [COL_W-1:0]   COL_LAST = COL_W'(COLS - 1);
   localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);

   typedef enum logic [7:0] {
      S_INIT     = 8'b0000_0001,
      S_IDLE     = 8'b0000_0010,
      S_DISPATCH = 8'b0000_0100,
      S_SCROLL   = 8'b0000_1000,
      S_BLANK    = 8'b0001_0000,
      S_CLEAR    = 8'b0010_0000,
      S_DIVIDE   = 8'b0100_0000,
      S_READ     = 8'b1000_0000
   } state_type;

   logic [15:0] cell_mem [CELL_COUNT];

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CELL_W-1:0] cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CELL_W-1:0] scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              scroll_ff, scroll_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;
   logic [15:0]       rd_data_ff;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [15:0]       mem_wd;
   logic              pop, fin;
   logic [7:0]        fin_char, fin_attr;
   logic [CELL_W-1:0] row_base;

   assign pop = (state_ff == S_IDLE) && cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign back_stat.pop       = pop;
   assign back_stat.init_busy = (state_ff == S_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign row_base = CELL_W'(prod_ff[PROD_W-1:Q_SHIFT]) * COLS_C;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      prod_in      = prod_ff;
      scroll_in    = scroll_ff;
      mem_we       = 1'b0;
      mem_wa       = scan_ff[ADDR_W-1:0];
      mem_wd       = {text_attr, 8'h00};
      mem_re       = 1'b0;
      mem_ra       = scan_ff[ADDR_W-1:0];
      fin          = 1'b0;
      fin_char     = 8'h00;
      fin_attr     = 8'h00;

      case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            mem_wd = 16'h0000;
            if (scan_ff == LAST_ONE) begin
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (pop) begin
               cmd_in    = cmd;
               scroll_in = 1'b0;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (cmd_ff.op)
               OP_PUTC, OP_NEWLINE: begin
                  if (cursor_ff == CELLS) begin
                     // past the end: scroll first, then come back here
                     scan_in   = COLS_C;
                     pend_in   = 1'b0;
                     scroll_in = 1'b1;
                     state_in  = S_SCROLL;
                  end else if (cmd_ff.op == OP_PUTC) begin
                     mem_we    = 1'b1;
                     mem_wa    = cursor_ff[ADDR_W-1:0];
                     mem_wd    = {text_attr, cmd_ff.char_code};
                     cursor_in = cursor_ff + 1'b1;
                     col_in    = (col_ff == COL_LAST) ? '0 : col_ff + 1'b1;
                     fin       = 1'b1;
                     state_in  = S_IDLE;
                  end else begin
                     cursor_in = cursor_ff - CELL_W'(col_ff) + COLS_C;
                     col_in    = '0;
                     fin       = 1'b1;
                     state_in  = S_IDLE;
                  end
               end
               OP_SETCUR: begin
                  if (cmd_ff.in_range) begin
                     prod_in  = PROD_W'(CELL_W'(cmd_ff.cell_index)) * PROD_W'(RECIP_C);
                     state_in = S_DIVIDE;
                  end else begin
                     fin      = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               OP_CLEAR: begin
                  scan_in  = '0;
                  state_in = S_CLEAR;
               end
               OP_READ: begin
                  if (cmd_ff.in_range) begin
                     mem_re   = 1'b1;
                     mem_ra   = ADDR_W'(cmd_ff.cell_index);
                     state_in = S_READ;
                  end else begin
                     fin      = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  fin      = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCROLL: begin
            // read one row ahead, write the word back a row up next cycle
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = pend_addr_ff;
               mem_wd = rd_data_ff;
            end
            if (scan_ff != CELLS) begin
               mem_re       = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = ADDR_W'(scan_ff - COLS_C);
               scan_in      = scan_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               scan_in  = LAST_ROW;
               state_in = S_BLANK;
            end
         end
         S_BLANK: begin
            mem_we = 1'b1;
            if (scan_ff == LAST_ONE) begin
               cursor_in = LAST_ROW;
               col_in    = '0;
               state_in  = S_DISPATCH;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_CLEAR: begin
            mem_we = 1'b1;
            if (scan_ff == LAST_ONE) begin
               fin      = 1'b1;
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_DIVIDE: begin
            // column is the index less the start of the row from the product
            cursor_in = CELL_W'(cmd_ff.cell_index);
            col_in    = COL_W'(CELL_W'(cmd_ff.cell_index) - row_base);
            fin       = 1'b1;
            state_in  = S_IDLE;
         end
         S_READ: begin
            fin      = 1'b1;
            fin_char = rd_data_ff[7:0];
            fin_attr = rd_data_ff[15:8];
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_item_in = rsp_item_ff;
      if (fin) begin
         rsp_valid_in           = 1'b1;
         rsp_item_in.cell_char  = fin_char;
         rsp_item_in.cell_attr  = fin_attr;
         rsp_item_in.cursor_now = 11'(cursor_in);
         rsp_item_in.scrolled   = scroll_in;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         scan_ff      <= '0;
         cursor_ff    <= '0;
         col_ff       <= '0;
         pend_ff      <= 1'b0;
         scroll_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         pend_ff      <= pend_in;
         scroll_ff    <= scroll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      pend_addr_ff <= pend_addr_in;
      prod_ff      <= prod_in;
      rsp_item_ff  <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= cell_mem[mem_ra];
      end
   end

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: attribute register on the APB-style
// port, front end queue and back end engine. Depends on tcw_pkg, tcw_front
// and tcw_back.
//
// Use: requests enter on req_valid/req_stall with a req_item word (put
// character, set cursor, clear screen, read cell); every request gives one
// rsp_item word on rsp_valid/rsp_stall with the read cell, the cursor after
// the request and a scroll flag. The attribute register sits at byte
// address 0 and is to be written by the user only while the block is idle;
// the block does not enforce this. A character, newline or out-of-range
// request finishes in S_DISPATCH and its result is registered; a read adds
// S_READ and a cursor set adds S_DIVIDE, which finds the column from a
// reciprocal product of the index. A scroll adds S_SCROLL and S_BLANK and a
// clear screen runs S_CLEAR, one cell a cycle on the single write port of
// the cell store, which sets the rate.
// A two-word queue sits between the input and the engine, so requests are
// taken while the engine is busy until the queue fills.
// After reset the store is swept to zero in S_INIT, during which
// req_stall is high. While rsp_stall is high the result word holds and the
// engine waits before starting the next request.
`timescale 1ns / 1ps

module text_console_writer #(
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
   parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcw_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tcw_pkg::rsp_item_type rsp_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import tcw_pkg::*;

   logic [7:0]    text_attr_ff, text_attr_in;
   logic          cmd_valid;
   cmd_type       cmd;
   back_stat_type back_stat;
   logic          attr_sel;

   assign csr_pready = 1'b1;
   assign attr_sel   = (csr_paddr[2] == 1'b0);
   assign csr_prdata = attr_sel ? {24'h0, text_attr_ff} : 32'h0;

   always_comb begin
      text_attr_in = text_attr_ff;
      if (csr_psel && csr_penable && csr_pwrite && attr_sel) begin
         text_attr_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff <= ATTR_RESET;
      end else begin
         text_attr_ff <= text_attr_in;
      end
   end

   tcw_front #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .back_stat (back_stat),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   tcw_back #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .text_attr (text_attr_ff),
      .back_stat (back_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for text_console_writer: drives request words, writes the
// attribute register over the APB-style port and checks every result word.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module tb;
   import tcw_pkg::*;

   localparam int ROWS          = ROWS_DEFAULT;
   localparam int COLS          = COLS_DEFAULT;
   localparam int CELLS         = ROWS * COLS;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = CELLS + 16;
   localparam int GAP_PERCENT   = 12;
   localparam int HEAVY_BUDGET  = 90;

   localparam logic [2:0]  ATTR_ADDR = 3'd0;
   localparam logic [10:0] END_CELL  = 11'(CELLS);
   localparam logic [10:0] LAST_CELL = 11'(CELLS - 1);
   localparam logic [10:0] LAST_ROW  = 11'(CELLS - COLS);

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_item_type req_item    = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [2:0]   csr_paddr   = '0;
   logic [31:0]  csr_pwdata  = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // shadow of the console
   logic [15:0]  shadow_cells [0:CELLS-1];
   int unsigned  shadow_cursor;
   logic [7:0]   shadow_attr;

   rsp_item_type pending_rsp [$];
   req_item_type dir_req [$];
   bit           dir_typed [$];
   rsp_item_type dir_want [$];

   bit   tx_gaps   = 1'b1;
   logic rx_quiet  = 1'b0;
   logic hold_go   = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;
   int   rx_burst  = 0;

   int req_sent       = 0;
   int rsp_seen       = 0;
   int scroll_seen    = 0;
   int clear_sent     = 0;
   int attr_writes    = 0;
   int mismatch_count = 0;
   int heavy_left     = HEAVY_BUDGET;

   text_console_writer #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic req_item_type mk_req(input logic [1:0] t, input logic [7:0] c,
                                           input logic [10:0] i);
      req_item_type r;
      r.req_type   = t;
      r.char_code  = c;
      r.cell_index = i;
      return r;
   endfunction

   function automatic rsp_item_type mk_rsp(input logic [7:0] ch, input logic [7:0] at,
                                           input logic [10:0] cur, input logic sc);
      rsp_item_type r;
      r.cell_char  = ch;
      r.cell_attr  = at;
      r.cursor_now = cur;
      r.scrolled   = sc;
      return r;
   endfunction

   function automatic string show_rsp(input rsp_item_type r);
      return $sformatf("char %02h attr %02h cursor %0d scroll %0d",
                       r.cell_char, r.cell_attr, r.cursor_now, r.scrolled);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
   endtask

   // Apply one request to the shadow console and return the word it should give.
   function automatic rsp_item_type console_predict(input req_item_type it);
      rsp_item_type r;
      int k;
      r = '0;
      if (shadow_cursor > CELLS) shadow_cursor = CELLS;
      case (it.req_type)
         REQ_PUT: begin
            // past the end: move every row up, blank the bottom one
            if (shadow_cursor >= CELLS) begin
               for (k = 0; k < CELLS - COLS; k++) shadow_cells[k] = shadow_cells[k + COLS];
               for (k = CELLS - COLS; k < CELLS; k++) shadow_cells[k] = {shadow_attr, 8'h00};
               shadow_cursor = CELLS - COLS;
               r.scrolled = 1'b1;
            end
            if (it.char_code == NEWLINE_CODE) begin
               shadow_cursor = (shadow_cursor / COLS) * COLS + COLS;
            end else begin
               shadow_cells[shadow_cursor] = {shadow_attr, it.char_code};
               shadow_cursor++;
            end
         end
         REQ_SET: begin
            if (it.cell_index < CELLS) shadow_cursor = 32'(it.cell_index);
         end
         REQ_CLEAR: begin
            for (k = 0; k < CELLS; k++) shadow_cells[k] = {shadow_attr, 8'h00};
         end
         default: begin
            if (it.cell_index < CELLS) begin
               r.cell_char = shadow_cells[it.cell_index][7:0];
               r.cell_attr = shadow_cells[it.cell_index][15:8];
            end
         end
      endcase
      r.cursor_now = shadow_cursor[10:0];
      return r;
   endfunction

   task automatic add_row(input req_item_type r, input bit typed, input rsp_item_type w);
      dir_req.push_back(r);
      dir_typed.push_back(typed);
      dir_want.push_back(w);
   endtask

   // Offer one word and hold it until taken; predict on acceptance.
   task automatic send_request(input req_item_type it, input bit typed,
                               input rsp_item_type want);
      rsp_item_type predicted;
      if (tx_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = console_predict(it);
      pending_rsp.push_back(typed ? want : predicted);
      req_sent++;
      if (it.req_type == REQ_CLEAR) clear_sent++;
   endtask

   // Cap the number of full-store passes so the run stays short.
   task automatic emit(input logic [1:0] t, input logic [7:0] c, input logic [10:0] i);
      logic [1:0]  kind;
      logic [10:0] idx;
      kind = t;
      idx  = i;
      if (kind == REQ_PUT && shadow_cursor >= CELLS) begin
         if (heavy_left == 0) begin
            kind = REQ_SET;
            idx  = 11'($urandom_range(0, CELLS - 1));
         end else begin
            heavy_left--;
         end
      end else if (kind == REQ_CLEAR) begin
         if (heavy_left == 0) kind = REQ_READ;
         else heavy_left--;
      end
      send_request(mk_req(kind, c, idx), 1'b0, '0);
   endtask

   task automatic type_text(input int len, input int stop_at);
      int k;
      for (k = 0; k < len && req_sent < stop_at; k++) begin
         if ($urandom_range(0, 99) < 15)
            emit(REQ_PUT, NEWLINE_CODE, 11'($urandom_range(0, 2047)));
         else
            emit(REQ_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end
   endtask

   task automatic run_random(input int count);
      int stop_at;
      int pick;
      int n;
      int k;
      logic [10:0] idx;
      stop_at = req_sent + count;
      while (req_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            type_text($urandom_range(1, 12), stop_at);
         end else if (pick < 50) begin
            // park near the bottom so the text runs off the end
            emit(REQ_SET, 8'($urandom_range(0, 255)), 11'(CELLS - $urandom_range(1, 8)));
            type_text($urandom_range(2, 10), stop_at);
         end else if (pick < 70) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n && req_sent < stop_at; k++) begin
               case ($urandom_range(0, 9))
                  0:       idx = 11'($urandom_range(0, 2047));
                  1, 2, 3: idx = 11'($urandom_range(0, CELLS - 1));
                  default: idx = (shadow_cursor > 20)
                                 ? 11'(shadow_cursor - $urandom_range(1, 20))
                                 : 11'($urandom_range(0, 20));
               endcase
               emit(REQ_READ, 8'($urandom_range(0, 255)), idx);
            end
         end else if (pick < 82) begin
            if ($urandom_range(0, 9) < 7)
               emit(REQ_SET, 8'($urandom_range(0, 255)), 11'($urandom_range(0, CELLS - 1)));
            else
               emit(REQ_SET, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
         end else if (pick < 85) begin
            emit(REQ_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
         end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n && req_sent < stop_at; k++)
               emit(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    11'($urandom_range(0, 2047)));
         end
      end
   endtask

   // Drop valid, drain all results, then let any store pass finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_attr(input logic [7:0] value);
      logic [31:0] data;
      data       = $urandom;
      data[7:0]  = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ATTR_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      shadow_attr = value;
      attr_writes++;
      // read back
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[7:0] !== value)
         note_mismatch($sformatf("attribute read back %02h, expected %02h",
                                 csr_prdata[7:0], value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // long receiver hold-off, armed once by the stimulus
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (rsp_item.scrolled) scroll_seen++;
         if (pending_rsp.size() == 0) begin
            note_mismatch($sformatf("result word with nothing expected: %s",
                                    show_rsp(rsp_item)));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.cell_char !== want.cell_char || rsp_item.cell_attr !== want.cell_attr
                || rsp_item.cursor_now !== want.cursor_now
                || rsp_item.scrolled !== want.scrolled)
               note_mismatch($sformatf("result %0d: expected %s, got %s", rsp_seen,
                                       show_rsp(want), show_rsp(rsp_item)));
         end
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
      end else if (rx_burst != 0) begin
         rsp_stall <= 1'b1;
         rx_burst  <= rx_burst - 1;
      end else if (!rx_quiet && $urandom_range(0, 99) < GAP_PERCENT) begin
         rsp_stall <= 1'b1;
         rx_burst  <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      int k;
      int p;
      logic [7:0] attr_plan [0:3];
      for (k = 0; k < CELLS; k++) shadow_cells[k] = '0;
      shadow_cursor = 0;
      shadow_attr   = ATTR_RESET;

      // after reset, extremes, out of range, scroll, newline and clear corners
      add_row(mk_req(REQ_READ, 8'h00, 11'd0), 1'b1, mk_rsp(8'h00, 8'h00, 11'd0, 1'b0));
      add_row(mk_req(REQ_READ, 8'hFF, 11'h7FF), 1'b1, mk_rsp(8'h00, 8'h00, 11'd0, 1'b0));
      add_row(mk_req(REQ_READ, 8'h00, END_CELL), 1'b1, mk_rsp(8'h00, 8'h00, 11'd0, 1'b0));
      add_row(mk_req(REQ_READ, 8'h00, LAST_CELL), 1'b1, mk_rsp(8'h00, 8'h00, 11'd0, 1'b0));
      add_row(mk_req(REQ_SET, 8'h00, END_CELL), 1'b1, mk_rsp(8'h00, 8'h00, 11'd0, 1'b0));
      add_row(mk_req(REQ_SET, 8'hFF, 11'h7FF), 1'b1, mk_rsp(8'h00, 8'h00, 11'd0, 1'b0));
      add_row(mk_req(REQ_PUT, 8'h41, 11'h7FF), 1'b1, mk_rsp(8'h00, 8'h00, 11'd1, 1'b0));
      add_row(mk_req(REQ_PUT, 8'h00, 11'd0), 1'b1, mk_rsp(8'h00, 8'h00, 11'd2, 1'b0));
      add_row(mk_req(REQ_PUT, 8'hFF, 11'd0), 1'b1, mk_rsp(8'h00, 8'h00, 11'd3, 1'b0));
      add_row(mk_req(REQ_READ, 8'h00, 11'd0), 1'b1,
              mk_rsp(8'h41, ATTR_RESET, 11'd3, 1'b0));
      add_row(mk_req(REQ_READ, 8'h00, 11'd2), 1'b1,
              mk_rsp(8'hFF, ATTR_RESET, 11'd3, 1'b0));
      add_row(mk_req(REQ_PUT, NEWLINE_CODE, 11'd0), 1'b1,
              mk_rsp(8'h00, 8'h00, 11'(COLS), 1'b0));
      add_row(mk_req(REQ_SET, 8'h00, LAST_CELL), 1'b1,
              mk_rsp(8'h00, 8'h00, LAST_CELL, 1'b0));
      add_row(mk_req(REQ_PUT, 8'h55, 11'd0), 1'b1, mk_rsp(8'h00, 8'h00, END_CELL, 1'b0));
      add_row(mk_req(REQ_PUT, 8'hAA, 11'h7FF), 1'b0, '0);
      add_row(mk_req(REQ_READ, 8'h00, LAST_ROW - 11'd1), 1'b0, '0);
      add_row(mk_req(REQ_READ, 8'h00, 11'd1), 1'b0, '0);
      add_row(mk_req(REQ_SET, 8'h00, LAST_ROW + 11'd10), 1'b1,
              mk_rsp(8'h00, 8'h00, LAST_ROW + 11'd10, 1'b0));
      add_row(mk_req(REQ_PUT, NEWLINE_CODE, 11'd0), 1'b1,
              mk_rsp(8'h00, 8'h00, END_CELL, 1'b0));
      add_row(mk_req(REQ_PUT, NEWLINE_CODE, 11'd0), 1'b1,
              mk_rsp(8'h00, 8'h00, END_CELL, 1'b1));
      add_row(mk_req(REQ_READ, 8'h00, LAST_ROW), 1'b0, '0);
      add_row(mk_req(REQ_CLEAR, 8'hFF, 11'h7FF), 1'b1,
              mk_rsp(8'h00, 8'h00, END_CELL, 1'b0));
      add_row(mk_req(REQ_READ, 8'h00, 11'd0), 1'b0, '0);
      add_row(mk_req(REQ_SET, 8'h00, 11'd0), 1'b1, mk_rsp(8'h00, 8'h00, 11'd0, 1'b0));
      add_row(mk_req(REQ_READ, 8'hFF, LAST_CELL), 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < dir_req.size(); k++) send_request(dir_req[k], dir_typed[k], dir_want[k]);
      wait_idle();

      attr_plan[0] = 8'h00;
      attr_plan[1] = 8'hFF;
      attr_plan[2] = 8'($urandom);
      attr_plan[3] = 8'($urandom);
      for (p = 0; p < 4; p++) begin
         write_attr(attr_plan[p]);
         run_random(100);
         if (p == 1) begin
            // keep offering while the receiver holds off, so the queue fills
            tx_gaps = 1'b0;
            hold_go <= 1'b1;
            for (k = 0; k < 30; k++) begin
               if ($urandom_range(0, 1))
                  emit(REQ_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
               else
                  emit(REQ_READ, 8'($urandom_range(0, 255)),
                       11'($urandom_range(0, CELLS - 1)));
            end
            tx_gaps = 1'b1;
         end
         wait_idle();
      end

      // closing stretch with no idling on either side
      write_attr(8'($urandom));
      tx_gaps = 1'b0;
      rx_quiet <= 1'b1;
      run_random(80);
      wait_idle();

      $display("Sent %0d requests (%0d clears) under %0d attribute settings;",
               req_sent, clear_sent, attr_writes + 1);
      $display("checked %0d result words, %0d of them with a scroll, %0d mismatches.",
               rsp_seen, scroll_seen, mismatch_count);
      if (pending_rsp.size() != 0) $display("%0d result words never arrived", pending_rsp.size());
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("Timed out with %0d result words outstanding", pending_rsp.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer.sv
bench/tb.sv
